// ===== rtl/core/rls_pkg.sv =====
// Shared types, constants and helper functions of the two-parameter RLS estimator.
package rls_pkg;

    // Forgetting factor limits and reset value, unsigned Q1.24.
    localparam logic [24:0] LAMBDA_MIN   = 25'd8388608;
    localparam logic [24:0] LAMBDA_MAX   = 25'd16777216;
    localparam logic [24:0] LAMBDA_RESET = 25'd16609443;

    // Steady regressor thresholds: per component magnitude and sum of squares.
    localparam logic [32:0] STEADY_COMP_LIMIT = 33'd16778;
    localparam logic [30:0] STEADY_SQ_LIMIT   = 31'd281474977;

    // Covariance diagonal after restart: 10.0 in Q16.32.
    localparam logic signed [47:0] COV_INIT = 48'sd42949672960;

    // Saturation bounds on magnitudes (negative bound; positive is one less).
    localparam logic [63:0] LIM32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LIM48 = 64'h0000_8000_0000_0000;
    localparam logic [63:0] LIM62 = 64'h2000_0000_0000_0000;

    // Numerator width of the serial divider, one quotient bit per cycle.
    localparam int DIV_STEPS = 96;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LAMBDA = 2'd0;
    localparam logic [1:0] CFG_INIT_D = 2'd1;
    localparam logic [1:0] CFG_INIT_K = 2'd2;

    typedef enum logic [1:0] {
        STS_UPDATED = 2'd0,
        STS_INVALID = 2'd1,
        STS_STEADY  = 2'd2,
        STS_RESTART = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    // Sequencer steps of one update, in execution order.
    typedef enum logic [4:0] {
        SP_U0A, SP_U0B, SP_U1A, SP_U1B,
        SP_W0A, SP_W0B, SP_W1A, SP_W1B,
        SP_DNA, SP_DNB,
        SP_G0, SP_G1,
        SP_KW0, SP_NP0, SP_KW1, SP_NP1,
        SP_KW2, SP_NP2, SP_KW3, SP_NP3,
        SP_PTA, SP_PTB,
        SP_TH0, SP_TH1,
        SP_ESQ
    } t_step;

    // Multiplier control: shift by 32 instead of 24, saturate to 32 instead of 62 bits.
    typedef struct packed {
        logic sh32;
        logic w32;
    } t_mul_ctl;

    // Divider control: numerator shift by 32 instead of 24, saturate to 48 instead of 62 bits.
    typedef struct packed {
        logic sh32;
        logic w48;
    } t_div_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] ext32(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic signed [63:0] ext33(input logic signed [32:0] x);
        return {{31{x[32]}}, x};
    endfunction

    function automatic logic signed [63:0] ext48(input logic signed [47:0] x);
        return {{16{x[47]}}, x};
    endfunction

    function automatic logic signed [63:0] ext62(input logic signed [61:0] x);
        return {{2{x[61]}}, x};
    endfunction

endpackage

// ===== rtl/core/rls_two_param_estimator_unit.sv =====
// Top level of the two-parameter RLS estimator: sequencer, state and handshakes.
// A restart, invalid or steady word passes through the output state into the output register;
// an update runs 19 products and six 96-step divisions on the shared units in sequencer order
// and then loads the output register, which waits while an earlier result is stalled.
// One word in work at a time: no new word is taken until its result is loaded for output.
// Synchronous active-low reset reloads lambda, clears ratios and estimates, sets P to 10*I.
module rls_two_param_estimator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_position_deviation,
    input  logic signed [31:0] i_acceleration,
    input  logic               i_sample_invalid,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_damping_estimate,
    output logic signed [31:0] o_stiffness_estimate,
    output logic signed [31:0] o_prediction_error,
    output logic [30:0]        o_error_squared,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rls_pkg::*;

    t_state r_state;
    t_state n_state;
    t_step  r_step;

    // Configuration and estimator state.
    logic [24:0]        r_lambda;
    logic signed [31:0] r_init_d;
    logic signed [31:0] r_init_k;
    logic signed [31:0] r_th0;
    logic signed [31:0] r_th1;
    logic signed [47:0] r_cov [4];

    // Per-update working registers.
    logic signed [32:0] r_phi0;
    logic signed [32:0] r_phi1;
    logic signed [31:0] r_y;
    logic [24:0]        r_lam;
    logic signed [63:0] r_t;
    logic signed [63:0] r_u0;
    logic signed [63:0] r_u1;
    logic signed [63:0] r_wv0;
    logic signed [63:0] r_wv1;
    logic signed [63:0] r_den;
    logic signed [61:0] r_g0;
    logic signed [61:0] r_g1;
    logic signed [63:0] r_diff;
    logic signed [31:0] r_err;
    logic [30:0]        r_esq;
    t_status            r_status;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic signed [31:0] r_o_damp;
    logic signed [31:0] r_o_stiff;
    logic signed [31:0] r_o_err;
    logic [30:0]        r_o_esq;

    // Shared unit connections.
    logic               w_mul_start;
    logic               w_div_start;
    logic signed [63:0] w_a;
    logic signed [63:0] w_b;
    t_mul_ctl           w_mctl;
    logic signed [63:0] w_dx;
    logic [63:0]        w_dd;
    t_div_ctl           w_dctl;
    logic               w_is_div;
    logic               w_mul_done;
    logic               w_div_done;
    logic signed [63:0] w_mul_res;
    logic signed [63:0] w_div_q;
    logic               w_done;
    logic               w_load_out;

    // Input-side decode.
    logic               w_accept;
    logic signed [32:0] w_phi0;
    logic signed [32:0] w_phi1;
    logic [32:0]        w_m0;
    logic [32:0]        w_m1;
    logic [29:0]        w_sq0;
    logic [29:0]        w_sq1;
    logic [30:0]        w_sqsum;
    logic               w_steady;
    logic [24:0]        w_lam;
    logic signed [63:0] w_lam64;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_den;

    assign w_accept = i_valid && o_ready;

    // Regressor is the negated velocity and pose deviation, kept at 33 bits.
    assign w_phi0 = -$signed({i_velocity[31], i_velocity});
    assign w_phi1 = -$signed({i_position_deviation[31], i_position_deviation});
    assign w_m0   = w_phi0[32] ? 33'(-w_phi0) : 33'(w_phi0);
    assign w_m1   = w_phi1[32] ? 33'(-w_phi1) : 33'(w_phi1);

    // Steady check on the component magnitudes and the squared norm of the regressor.
    assign w_sq0    = 30'(w_m0[14:0]) * 30'(w_m0[14:0]);
    assign w_sq1    = 30'(w_m1[14:0]) * 30'(w_m1[14:0]);
    assign w_sqsum  = 31'(w_sq0) + 31'(w_sq1);
    assign w_steady = (w_m0 < STEADY_COMP_LIMIT) && (w_m1 < STEADY_COMP_LIMIT) &&
                      (w_sqsum < STEADY_SQ_LIMIT);

    // Forgetting factor clamped to its legal range.
    assign w_lam   = (r_lambda < LAMBDA_MIN) ? LAMBDA_MIN :
                     (r_lambda > LAMBDA_MAX) ? LAMBDA_MAX : r_lambda;
    assign w_lam64 = $signed({31'd0, r_lam, 8'd0});

    // Running sum of two products, and the denominator with lambda added before its clamp.
    assign w_sum = r_t + w_mul_res;
    assign w_den = w_sum + w_lam64;

    // Operand selection per sequencer step.
    always_comb begin
        w_a      = '0;
        w_b      = '0;
        w_mctl   = '{sh32: 1'b0, w32: 1'b0};
        w_dx     = '0;
        w_dd     = '0;
        w_dctl   = '{sh32: 1'b0, w48: 1'b0};
        w_is_div = 1'b0;
        unique case (r_step) inside
            SP_U0A: begin w_a = ext48(r_cov[0]); w_b = ext33(r_phi0); end
            SP_U0B: begin w_a = ext48(r_cov[1]); w_b = ext33(r_phi1); end
            SP_U1A: begin w_a = ext48(r_cov[2]); w_b = ext33(r_phi0); end
            SP_U1B: begin w_a = ext48(r_cov[3]); w_b = ext33(r_phi1); end
            SP_W0A: begin w_a = ext33(r_phi0); w_b = ext48(r_cov[0]); end
            SP_W0B: begin w_a = ext33(r_phi1); w_b = ext48(r_cov[2]); end
            SP_W1A: begin w_a = ext33(r_phi0); w_b = ext48(r_cov[1]); end
            SP_W1B: begin w_a = ext33(r_phi1); w_b = ext48(r_cov[3]); end
            SP_DNA: begin w_a = ext33(r_phi0); w_b = r_u0; end
            SP_DNB: begin w_a = ext33(r_phi1); w_b = r_u1; end
            SP_G0: begin
                w_is_div = 1'b1;
                w_dx     = r_u0;
                w_dd     = 64'(r_den);
                w_dctl   = '{sh32: 1'b1, w48: 1'b0};
            end
            SP_G1: begin
                w_is_div = 1'b1;
                w_dx     = r_u1;
                w_dd     = 64'(r_den);
                w_dctl   = '{sh32: 1'b1, w48: 1'b0};
            end
            SP_KW0: begin
                w_a = ext62(r_g0); w_b = r_wv0; w_mctl = '{sh32: 1'b1, w32: 1'b0};
            end
            SP_KW1: begin
                w_a = ext62(r_g0); w_b = r_wv1; w_mctl = '{sh32: 1'b1, w32: 1'b0};
            end
            SP_KW2: begin
                w_a = ext62(r_g1); w_b = r_wv0; w_mctl = '{sh32: 1'b1, w32: 1'b0};
            end
            SP_KW3: begin
                w_a = ext62(r_g1); w_b = r_wv1; w_mctl = '{sh32: 1'b1, w32: 1'b0};
            end
            SP_NP0, SP_NP1, SP_NP2, SP_NP3: begin
                w_is_div = 1'b1;
                w_dx     = r_diff;
                w_dd     = {39'd0, r_lam};
                w_dctl   = '{sh32: 1'b0, w48: 1'b1};
            end
            SP_PTA: begin w_a = ext33(r_phi0); w_b = ext32(r_th0); end
            SP_PTB: begin w_a = ext33(r_phi1); w_b = ext32(r_th1); end
            SP_TH0: begin
                w_a = ext62(r_g0); w_b = ext32(r_err); w_mctl = '{sh32: 1'b1, w32: 1'b0};
            end
            SP_TH1: begin
                w_a = ext62(r_g1); w_b = ext32(r_err); w_mctl = '{sh32: 1'b1, w32: 1'b0};
            end
            SP_ESQ: begin
                w_a = ext32(r_err); w_b = ext32(r_err); w_mctl = '{sh32: 1'b0, w32: 1'b1};
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    assign w_done = w_is_div ? w_div_done : w_mul_done;

    // Sequencer: next state and unit start strobes.
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_command || i_sample_invalid || w_steady) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                w_mul_start = !w_is_div;
                w_div_start = w_is_div;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = (r_step == SP_ESQ) ? ST_OUT : ST_ISSUE;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes, estimator state and step write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= SP_U0A;
            r_lambda <= LAMBDA_RESET;
            r_init_d <= '0;
            r_init_k <= '0;
            r_th0    <= '0;
            r_th1    <= '0;
            r_cov[0] <= COV_INIT;
            r_cov[1] <= '0;
            r_cov[2] <= '0;
            r_cov[3] <= COV_INIT;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LAMBDA: r_lambda <= i_cfg_data[24:0];
                    CFG_INIT_D: r_init_d <= $signed(i_cfg_data);
                    CFG_INIT_K: r_init_k <= $signed(i_cfg_data);
                    default:    r_lambda <= r_lambda;
                endcase
            end

            // Accepted word: classify and latch the operands.
            if (w_accept) begin
                r_step <= SP_U0A;
                r_err  <= '0;
                r_esq  <= '0;
                r_phi0 <= w_phi0;
                r_phi1 <= w_phi1;
                r_y    <= i_acceleration;
                r_lam  <= w_lam;
                if (i_command) begin
                    r_status <= STS_RESTART;
                    r_th0    <= r_init_d;
                    r_th1    <= r_init_k;
                    r_cov[0] <= COV_INIT;
                    r_cov[1] <= '0;
                    r_cov[2] <= '0;
                    r_cov[3] <= COV_INIT;
                end else if (i_sample_invalid) begin
                    r_status <= STS_INVALID;
                end else if (w_steady) begin
                    r_status <= STS_STEADY;
                end else begin
                    r_status <= STS_UPDATED;
                end
            end

            // Result of the finished step.
            if (r_state == ST_WAIT && w_done) begin
                r_step <= t_step'(r_step + 5'd1);
                case (r_step) inside
                    SP_U0A, SP_U1A, SP_W0A, SP_W1A, SP_DNA, SP_PTA: r_t <= w_mul_res;
                    SP_U0B: r_u0  <= w_sum;
                    SP_U1B: r_u1  <= w_sum;
                    SP_W0B: r_wv0 <= w_sum;
                    SP_W1B: r_wv1 <= w_sum;
                    SP_DNB: r_den <= (w_den < w_lam64) ? w_lam64 : w_den;
                    SP_G0:  r_g0  <= w_div_q[61:0];
                    SP_G1:  r_g1  <= w_div_q[61:0];
                    SP_KW0: r_diff <= ext48(r_cov[0]) - w_mul_res;
                    SP_KW1: r_diff <= ext48(r_cov[1]) - w_mul_res;
                    SP_KW2: r_diff <= ext48(r_cov[2]) - w_mul_res;
                    SP_KW3: r_diff <= ext48(r_cov[3]) - w_mul_res;
                    SP_NP0: r_cov[0] <= w_div_q[47:0];
                    SP_NP1: r_cov[1] <= w_div_q[47:0];
                    SP_NP2: r_cov[2] <= w_div_q[47:0];
                    SP_NP3: r_cov[3] <= w_div_q[47:0];
                    SP_PTB: r_err <= sat32(ext32(r_y) - w_sum);
                    SP_TH0: r_th0 <= sat32(ext32(r_th0) + w_mul_res);
                    SP_TH1: r_th1 <= sat32(ext32(r_th1) + w_mul_res);
                    SP_ESQ: r_esq <= w_mul_res[30:0];
                    default: r_t  <= r_t;
                endcase
            end
        end
    end

    // Output register: holds a word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_status <= r_status;
            r_o_damp   <= r_th0;
            r_o_stiff  <= r_th1;
            r_o_err    <= r_err;
            r_o_esq    <= r_esq;
        end
    end

    rls_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_ctl   (w_mctl),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    rls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_x     (w_dx),
        .i_d     (w_dd),
        .i_ctl   (w_dctl),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    assign o_ready              = (r_state == ST_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_valid              = r_out_valid;
    assign o_status             = r_o_status;
    assign o_damping_estimate   = r_o_damp;
    assign o_stiffness_estimate = r_o_stiff;
    assign o_prediction_error   = r_o_err;
    assign o_error_squared      = r_o_esq;

endmodule

// ===== rtl/core/rls_mul.sv =====
// Shared multiply unit: 32x32 partial products, rounding shift and saturation.
module rls_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [63:0]    i_a,
    input  logic signed [63:0]    i_b,
    input  rls_pkg::t_mul_ctl     i_ctl,
    output logic                  o_done,
    output logic signed [63:0]    o_res
);
    import rls_pkg::*;

    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    t_mul_ctl     r_ctl;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic signed [63:0] r_res;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_prod;
    logic [1:0]   w_pidx;
    logic [127:0] w_pp_sh;
    logic [127:0] w_shifted;
    logic [63:0]  w_lim;
    logic [63:0]  w_mag;

    // Pick the halves for the current partial product.
    assign w_ah   = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign w_bh   = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign w_prod = w_ah * w_bh;
    assign w_pidx = 2'(r_cnt - 3'd1);

    // Align the registered partial product before accumulation.
    always_comb begin
        case (w_pidx)
            2'd0:    w_pp_sh = {64'd0, r_pp};
            2'd3:    w_pp_sh = {r_pp, 64'd0};
            default: w_pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    // Scale down and clamp the rounded magnitude.
    assign w_shifted = r_ctl.sh32 ? (r_acc >> 32) : (r_acc >> 24);
    assign w_lim     = (r_ctl.w32 ? LIM32 : LIM62) - {63'd0, ~r_neg};
    assign w_mag     = (w_shifted > {64'd0, w_lim}) ? w_lim : w_shifted[63:0];

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands, partial products, accumulator and result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_ctl <= i_ctl;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp <= w_prod;
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + w_pp_sh;
            end
            if (r_cnt == 3'd5) begin
                r_acc <= r_acc + (r_ctl.sh32 ? 128'h8000_0000 : 128'h80_0000);
            end
            if (r_cnt == 3'd6) begin
                r_res <= r_neg ? -$signed(w_mag) : $signed(w_mag);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/rls_div.sv =====
// Restoring bit-serial divider with a pre-shifted numerator and saturated quotient.
module rls_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [63:0]    i_x,
    input  logic [63:0]           i_d,
    input  rls_pkg::t_div_ctl     i_ctl,
    output logic                  o_done,
    output logic signed [63:0]    o_q
);
    import rls_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [DIV_STEPS-1:0] r_num;
    logic [63:0]          r_rem;
    logic [63:0]          r_d;
    logic                 r_neg;
    t_div_ctl             r_ctl;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic signed [63:0]   r_q;

    logic [63:0]          w_mag;
    logic [DIV_STEPS-1:0] w_num;
    logic [64:0]          w_trial;
    logic [64:0]          w_diff;
    logic                 w_ge;
    logic [63:0]          w_lim;
    logic [63:0]          w_qmag;

    // Magnitude of the dividend, scaled by 2^32 or 2^24.
    assign w_mag = i_x[63] ? 64'(-i_x) : 64'(i_x);
    assign w_num = i_ctl.sh32 ? DIV_STEPS'({w_mag, 32'd0}) : DIV_STEPS'({w_mag, 24'd0});

    // One compare and subtract per cycle.
    assign w_trial = {r_rem, r_num[DIV_STEPS-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    // Final clamp of the quotient magnitude.
    assign w_lim  = (r_ctl.w48 ? LIM48 : LIM62) - {63'd0, ~r_neg};
    assign w_qmag = (r_num > DIV_STEPS'(w_lim)) ? w_lim : r_num[63:0];

    // Control: step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_num;
            r_rem <= '0;
            r_d   <= i_d;
            r_neg <= i_x[63];
            r_ctl <= i_ctl;
        end else if (r_busy) begin
            if (r_cnt < CNT_W'(DIV_STEPS)) begin
                r_rem <= w_ge ? w_diff[63:0] : w_trial[63:0];
                r_num <= {r_num[DIV_STEPS-2:0], w_ge};
            end else begin
                r_q <= r_neg ? -$signed(w_qmag) : $signed(w_qmag);
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ===== rtl/core/rls_chk.sv =====
// Port-level checker of the RLS estimator and its bind to the top level.
module rls_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_damping_estimate,
    input logic signed [31:0] o_stiffness_estimate,
    input logic signed [31:0] o_prediction_error,
    input logic [30:0]        o_error_squared
);
    import rls_pkg::*;

    // A stalled result word keeps its status and its estimates.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
        $stable(o_damping_estimate) && $stable(o_stiffness_estimate))
        else $error("result word changed while stalled");

    // Only an updated word carries an error and its square.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STS_UPDATED |->
        o_prediction_error == 32'sd0 && o_error_squared == 31'd0)
        else $error("error reported on a word that did not update");

    // The block works on one word at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word accepted while busy");

    // A zero error has a zero square.
    a_esq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_prediction_error == 32'sd0 |-> o_error_squared == 31'd0)
        else $error("nonzero square of a zero error");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind rls_two_param_estimator_unit rls_chk u_rls_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the two-parameter RLS estimator unit.
`timescale 1ns / 100ps

module testbench;
    import rls_pkg::*;

    // One expected result word.
    typedef struct {
        t_status            status;
        logic signed [31:0] damping;
        logic signed [31:0] stiffness;
        logic signed [31:0] pred_err;
        logic [30:0]        err_sq;
    } t_estimate;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_command;
    logic signed [31:0] i_velocity;
    logic signed [31:0] i_position_deviation;
    logic signed [31:0] i_acceleration;
    logic               i_sample_invalid;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_damping_estimate;
    logic signed [31:0] o_stiffness_estimate;
    logic signed [31:0] o_prediction_error;
    logic [30:0]        o_error_squared;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    // Mirror of the estimator state and registers.
    logic [24:0]        lambda_reg;
    logic signed [31:0] init_damping;
    logic signed [31:0] init_stiffness;
    logic signed [31:0] theta [2];
    logic signed [47:0] cov [4];

    t_estimate estimate_queue [$];
    bit        broken;
    bit        calm;
    int        cycle_count;

    rls_two_param_estimator_unit DUT (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 12000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // round(a*b / 2^sh) half away from zero, saturated to w bits.
    function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
            input logic signed [63:0] b, input int sh, input int w);
        logic [127:0] ma, mb, p, lim;
        logic neg;
        neg = (a < 0) != (b < 0);
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        p = ((ma * mb) + (128'd1 << (sh - 1))) >> sh;
        lim = neg ? (128'd1 << (w - 1)) : ((128'd1 << (w - 1)) - 1);
        if (p > lim) p = lim;
        return neg ? -64'(p) : 64'(p);
    endfunction

    // trunc(x * 2^sh / d), saturated to w bits.
    function automatic logic signed [63:0] div_trunc(input logic signed [63:0] x,
            input int sh, input logic [63:0] d, input int w);
        logic [127:0] q, lim;
        logic neg;
        neg = x < 0;
        q = (128'(x < 0 ? -x : x) << sh) / 128'(d);
        lim = neg ? (128'd1 << (w - 1)) : ((128'd1 << (w - 1)) - 1);
        if (q > lim) q = lim;
        return neg ? -64'(q) : 64'(q);
    endfunction

    function automatic logic signed [31:0] add_sat32(input logic signed [63:0] a,
            input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    // Advance the mirrored estimator by one sample and queue its result.
    task automatic predict_estimate(input logic cmd, input logic signed [31:0] vel,
            input logic signed [31:0] dev, input logic signed [31:0] acc, input logic inv);
        t_estimate e;
        logic signed [63:0] phi [2];
        logic signed [63:0] u [2];
        logic signed [63:0] wv [2];
        logic signed [63:0] gain [2];
        logic signed [63:0] newp [4];
        logic signed [63:0] den, lam32, pt, diff;
        logic [63:0] m0, m1, lam;
        e.pred_err = '0;
        e.err_sq = '0;
        phi[0] = -64'(vel);
        phi[1] = -64'(dev);
        m0 = phi[0] < 0 ? -phi[0] : phi[0];
        m1 = phi[1] < 0 ? -phi[1] : phi[1];
        if (cmd) begin
            theta[0] = init_damping;
            theta[1] = init_stiffness;
            cov[0] = COV_INIT;
            cov[1] = '0;
            cov[2] = '0;
            cov[3] = COV_INIT;
            e.status = STS_RESTART;
        end else if (inv) begin
            e.status = STS_INVALID;
        end else if (m0 < 16778 && m1 < 16778 && m0 * m0 + m1 * m1 < 281474977) begin
            e.status = STS_STEADY;
        end else begin
            lam = 64'(lambda_reg);
            if (lam < 64'(LAMBDA_MIN)) lam = 64'(LAMBDA_MIN);
            if (lam > 64'(LAMBDA_MAX)) lam = 64'(LAMBDA_MAX);
            lam32 = lam << 8;
            for (int i = 0; i < 2; i++) begin
                u[i] = mul_round(cov[i * 2], phi[0], 24, 62)
                     + mul_round(cov[i * 2 + 1], phi[1], 24, 62);
                wv[i] = mul_round(phi[0], cov[i], 24, 62)
                      + mul_round(phi[1], cov[2 + i], 24, 62);
            end
            den = lam32 + mul_round(phi[0], u[0], 24, 62) + mul_round(phi[1], u[1], 24, 62);
            if (den < lam32) den = lam32;
            for (int i = 0; i < 2; i++) gain[i] = div_trunc(u[i], 32, den, 62);
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    diff = cov[i * 2 + j] - mul_round(gain[i], wv[j], 32, 62);
                    newp[i * 2 + j] = div_trunc(diff, 24, lam, 48);
                end
            end
            for (int i = 0; i < 4; i++) cov[i] = newp[i][47:0];
            pt = mul_round(phi[0], theta[0], 24, 62) + mul_round(phi[1], theta[1], 24, 62);
            e.pred_err = add_sat32(acc, -pt);
            for (int i = 0; i < 2; i++)
                theta[i] = add_sat32(theta[i], mul_round(gain[i], e.pred_err, 32, 62));
            e.err_sq = 31'(mul_round(e.pred_err, e.pred_err, 24, 32));
            e.status = STS_UPDATED;
        end
        e.damping = theta[0];
        e.stiffness = theta[1];
        estimate_queue.push_back(e);
    endtask

    // Send one sample word, with an occasional random hold-off before it outside calm phases.
    task automatic send_sample(input logic cmd, input logic signed [31:0] vel,
            input logic signed [31:0] dev, input logic signed [31:0] acc, input logic inv);
        bit taken;
        if (!calm && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_velocity <= vel;
        i_position_deviation <= dev;
        i_acceleration <= acc;
        i_sample_invalid <= inv;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        predict_estimate(cmd, vel, dev, acc, inv);
    endtask

    // Write one register once the estimator has drained.
    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        bit taken;
        i_valid <= 1'b0;
        wait (estimate_queue.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        case (index)
            CFG_LAMBDA: lambda_reg = data[24:0];
            CFG_INIT_D: init_damping = data;
            CFG_INIT_K: init_stiffness = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver stalls.
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 31);
    end

    // Compare each accepted result word with the oldest expectation.
    always @(negedge i_clk) begin
        t_estimate e;
        if (i_rst_n && o_valid && i_ready) begin
            if (estimate_queue.size() == 0) begin
                $error("result word with nothing expected");
                broken = 1'b1;
            end else begin
                e = estimate_queue.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    broken = 1'b1;
                end
                if (o_damping_estimate !== e.damping) begin
                    $error("damping_estimate: expected %0d, got %0d",
                           e.damping, o_damping_estimate);
                    broken = 1'b1;
                end
                if (o_stiffness_estimate !== e.stiffness) begin
                    $error("stiffness_estimate: expected %0d, got %0d",
                           e.stiffness, o_stiffness_estimate);
                    broken = 1'b1;
                end
                if (o_prediction_error !== e.pred_err) begin
                    $error("prediction_error: expected %0d, got %0d",
                           e.pred_err, o_prediction_error);
                    broken = 1'b1;
                end
                if (o_error_squared !== e.err_sq) begin
                    $error("error_squared: expected %0d, got %0d", e.err_sq, o_error_squared);
                    broken = 1'b1;
                end
            end
        end
    end

    // A sample consistent with a plant of the given ratios, plus small noise.
    task automatic send_plant_sample(input logic signed [31:0] d, input logic signed [31:0] k);
        logic signed [31:0] vel, dev;
        logic signed [63:0] acc;
        vel = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        dev = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        acc = ((-64'(vel) * d) - (64'(dev) * k)) >>> 24;
        acc = acc + $signed($urandom_range(0, 2000)) - 1000;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        send_sample(1'b0, vel, dev, acc[31:0], 1'b0);
    endtask

    // Extremes, restart priority, invalid samples and the steady threshold.
    task automatic test_special_cases;
        send_sample(1'b1, '0, '0, '0, 1'b1);
        send_sample(1'b0, 32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 1'b1);
        send_sample(1'b0, '0, '0, 32'sh7FFF_FFFF, 1'b0);
        send_sample(1'b0, 32'sd16777, -32'sd16777, '0, 1'b0);
        send_sample(1'b0, 32'sd16778, '0, 32'sh0010_0000, 1'b0);
        send_sample(1'b0, '0, -32'sd16778, 32'sh0010_0000, 1'b0);
        send_sample(1'b0, 32'sd11863, 32'sd11863, 32'sh0000_1000, 1'b0);
        send_sample(1'b0, -32'sd11864, 32'sd11864, 32'sh0000_1000, 1'b0);
        send_sample(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_sample(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_sample(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_sample(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_sample(1'b0, 32'sh0100_0000, -32'sh0080_0000, 32'sh0300_0000, 1'b0);
        send_sample(1'b0, -32'sh0100_0000, 32'sh0080_0000, -32'sh0300_0000, 1'b0);
    endtask

    // Register sweep: lambda extremes, out of range values and initial ratios.
    task automatic test_register_settings;
        logic [31:0] lambdas [6];
        lambdas = '{32'h0000_0000, 32'h0080_0000, 32'h0100_0000,
                    32'hFFFF_FFFF, 32'h00FD_70A3, 32'h0120_0000};
        foreach (lambdas[n]) begin
            write_register(CFG_LAMBDA, lambdas[n]);
            write_register(CFG_INIT_D, n[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
            write_register(CFG_INIT_K, n[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
            send_sample(1'b1, '0, '0, '0, 1'b0);
            repeat (6) send_plant_sample(32'sh0200_0000, 32'sh0800_0000);
        end
    endtask

    // Random phases: mostly plant-consistent runs after a restart, some noise.
    task automatic test_random_traffic;
        logic signed [31:0] d, k;
        int pick;
        for (int phase = 0; phase < 30; phase++) begin
            calm = (phase >= 12 && phase < 16);
            d = $signed($urandom_range(0, 32'h0A00_0000));
            k = $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
            write_register(CFG_LAMBDA, $urandom_range(32'h00E0_0000, 32'h0100_0000));
            write_register(CFG_INIT_D, $urandom);
            write_register(CFG_INIT_K, $urandom);
            send_sample(1'b1, $urandom, $urandom, $urandom, 1'(phase));
            repeat (50) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_plant_sample(d, k);
                end else if (pick < 78) begin
                    send_sample(1'b0, $urandom, $urandom, $urandom, 1'b0);
                end else if (pick < 86) begin
                    send_sample(1'b0, $urandom, $urandom, $urandom, 1'b1);
                end else if (pick < 96) begin
                    send_sample(1'b0, $signed($urandom_range(0, 33556)) - 16778,
                                $signed($urandom_range(0, 33556)) - 16778, $urandom, 1'b0);
                end else begin
                    send_sample(1'b1, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        broken = 1'b0;
        calm = 1'b0;
        lambda_reg = LAMBDA_RESET;
        init_damping = '0;
        init_stiffness = '0;
        theta[0] = '0;
        theta[1] = '0;
        cov[0] = COV_INIT;
        cov[1] = '0;
        cov[2] = '0;
        cov[3] = COV_INIT;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= 1'b0;
        i_velocity <= '0;
        i_position_deviation <= '0;
        i_acceleration <= '0;
        i_sample_invalid <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_register_settings();
        test_random_traffic();

        i_valid <= 1'b0;
        wait (estimate_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        if (!broken) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rls_pkg.sv
rtl/core/rls_mul.sv
rtl/core/rls_div.sv
rtl/core/rls_two_param_estimator_unit.sv
rtl/core/rls_chk.sv
bench/testbench.sv
